### hw/rtl/srtq_pkg.sv
`default_nettype none
package srtq_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_REPORT_DEF  = 64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  age;
        logic [31:0] worth;
    } rec_t;

    typedef struct packed {
        logic        func;
        logic [63:0] person_name;
        logic [7:0]  person_age;
        logic [31:0] person_worth;
        logic [6:0]  report_limit;
        logic [7:0]  age_low;
        logic [7:0]  age_high;
    } in_word_t;

    typedef struct packed {
        logic [15:0] query_number;
        logic        found;
        logic [63:0] out_name;
        logic [7:0]  out_age;
        logic [31:0] out_worth;
        logic        last;
    } out_word_t;

    // True if record a must come strictly before record b in table order.
    function automatic logic goes_before(input rec_t a, input rec_t b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a.worth ^ 32'h8000_0000;
        kb = b.worth ^ 32'h8000_0000;
        if (ka != kb) begin
            return ka > kb;
        end
        if (a.age != b.age) begin
            return a.age < b.age;
        end
        return a.name < b.name;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/srtq_table_ram.sv
`default_nettype none
module srtq_table_ram #(
    parameter int DEPTH = srtq_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                 aclk,
    input  wire                 wr_en,
    input  wire [AW-1:0]        wr_addr,
    input  wire srtq_pkg::rec_t wr_data,
    input  wire [AW-1:0]        rd_addr,
    output srtq_pkg::rec_t      rd_data
);

    srtq_pkg::rec_t mem [DEPTH];
    srtq_pkg::rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hw/rtl/sorted_record_topk_range_query.sv
// Load: the search scans from the head, then the tail is shifted one entry up on the single
// record memory; each shifted entry is read, then written.
// Query: each scanned record is read, then tested; one item in flight.
// Results leave through one output register; a stall on m_ready holds the scan.
// Reset (aresetn low, synchronous) empties the table and clears the query number; record
// memory contents are not cleared, since only entries below the record count are ever read.
`default_nettype none
module sorted_record_topk_range_query #(
    parameter int TABLE_DEPTH = srtq_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_REPORT  = srtq_pkg::MAX_REPORT_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire srtq_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output srtq_pkg::out_word_t      m_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_SHIFT, ST_PUT, ST_SCAN, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [15:0]   qnum_reg;
    logic [CW-1:0] idx_reg;
    logic          rd_pend_reg;
    srtq_pkg::in_word_t cmd_reg;
    logic [6:0]    limit_reg;
    logic [6:0]    nrep_reg;
    logic          out_valid_reg;
    srtq_pkg::out_word_t out_reg;
    srtq_pkg::rec_t pend_reg;
    logic          pend_ok_reg;
    logic [CW-1:0] ins_pos_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    srtq_pkg::rec_t wr_data;
    logic [AW-1:0] rd_addr;
    srtq_pkg::rec_t rd_data;
    srtq_pkg::rec_t new_rec;

    srtq_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign new_rec.name  = cmd_reg.person_name;
    assign new_rec.age   = cmd_reg.person_age;
    assign new_rec.worth = cmd_reg.person_worth;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Read addresses: search and scan walk upward; shift reads the entry below idx.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        rd_addr = idx_reg[AW-1:0];
        if (state_reg == ST_SHIFT) begin
            rd_addr = AW'(idx_reg - CW'(1));
            wr_en   = rd_pend_reg;
            wr_data = rd_data;
        end else if (state_reg == ST_PUT) begin
            wr_en   = 1'b1;
            wr_data = new_rec;
        end
    end

    logic in_range;
    assign in_range = (rd_data.age >= cmd_reg.age_low) && (rd_data.age <= cmd_reg.age_high);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            qnum_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            pend_ok_reg   <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    rd_pend_reg <= 1'b0;
                    if (s_valid) begin
                        cmd_reg <= s_data;
                        idx_reg <= '0;
                        nrep_reg <= '0;
                        limit_reg <= (s_data.report_limit > 7'(MAX_REPORT)) ?
                                     7'(MAX_REPORT) : s_data.report_limit;
                        if (s_data.func == srtq_pkg::FUNC_QUERY) begin
                            qnum_reg  <= qnum_reg + 16'd1;
                            state_reg <= ST_SCAN;
                        end else if (count_reg < CW'(TABLE_DEPTH)) begin
                            state_reg <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    // rd_pend marks that rd_data holds entry idx.
                    if (!rd_pend_reg) begin
                        if (idx_reg == count_reg) begin
                            state_reg <= ST_PUT;
                        end else begin
                            rd_pend_reg <= 1'b1;
                        end
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (srtq_pkg::goes_before(new_rec, rd_data)) begin
                            // Insertion point found; shift from the top down.
                            pend_reg  <= rd_data;
                            state_reg <= ST_SHIFT;
                            idx_reg   <= count_reg;
                            cmd_reg.report_limit <= cmd_reg.report_limit;
                            limit_reg <= 7'(0);
                            nrep_reg  <= 7'(0);
                            pend_ok_reg <= 1'b0;
                            // Remember insertion position in a spare register.
                            ins_pos_reg <= idx_reg;
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                end
                ST_SHIFT: begin
                    if (idx_reg == ins_pos_reg) begin
                        state_reg <= ST_PUT;
                        rd_pend_reg <= 1'b0;
                    end else if (!rd_pend_reg) begin
                        rd_pend_reg <= 1'b1;
                    end else begin
                        // Write of entry idx-1 into idx happens this cycle.
                        rd_pend_reg <= 1'b0;
                        idx_reg     <= idx_reg - CW'(1);
                    end
                end
                ST_PUT: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (!rd_pend_reg) begin
                        if (idx_reg == count_reg || nrep_reg == limit_reg) begin
                            // The final word waits until the output register is free.
                            if (!out_valid_reg || m_ready) begin
                                if (nrep_reg == 7'd0) begin
                                    out_reg.query_number <= qnum_reg;
                                    out_reg.found     <= 1'b0;
                                    out_reg.out_name  <= '0;
                                    out_reg.out_age   <= '0;
                                    out_reg.out_worth <= '0;
                                    out_reg.last      <= 1'b1;
                                    pend_ok_reg       <= 1'b0;
                                    state_reg         <= ST_EMIT;
                                end else begin
                                    // Held record becomes the final one.
                                    out_reg.query_number <= qnum_reg;
                                    out_reg.found     <= 1'b1;
                                    out_reg.out_name  <= pend_reg.name;
                                    out_reg.out_age   <= pend_reg.age;
                                    out_reg.out_worth <= pend_reg.worth;
                                    out_reg.last      <= 1'b1;
                                    pend_ok_reg       <= 1'b0;
                                    state_reg         <= ST_EMIT;
                                end
                            end
                        end else begin
                            rd_pend_reg <= 1'b1;
                        end
                    end else if (!pend_ok_reg || !out_valid_reg || m_ready) begin
                        // One match is held back so its last flag is known.
                        rd_pend_reg <= 1'b0;
                        idx_reg     <= idx_reg + CW'(1);
                        if (in_range) begin
                            nrep_reg    <= nrep_reg + 7'd1;
                            pend_reg    <= rd_data;
                            pend_ok_reg <= 1'b1;
                            if (pend_ok_reg) begin
                                out_reg.query_number <= qnum_reg;
                                out_reg.found     <= 1'b1;
                                out_reg.out_name  <= pend_reg.name;
                                out_reg.out_age   <= pend_reg.age;
                                out_reg.out_worth <= pend_reg.worth;
                                out_reg.last      <= 1'b0;
                                out_valid_reg     <= 1'b1;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/srtq_checker.sv
`default_nettype none
module srtq_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire srtq_pkg::in_word_t  s_data,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire srtq_pkg::out_word_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.last && m_data.out_worth == 32'd0)
        else $error("none marker malformed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func |=> !s_ready)
        else $error("query accepted while another is running");

    a_qnum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> ##0
        (!m_valid || m_data.query_number == $past(m_data.query_number)))
        else $error("query number changed within one query");

endmodule

bind sorted_record_topk_range_query srtq_checker u_srtq_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
`default_nettype wire

### dv/topk_checker.sv
`timescale 1ns / 100ps
module topk_checker (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    input  wire                  s_ready,
    input  srtq_pkg::in_word_t   s_data,
    input  wire                  m_valid,
    input  wire                  m_ready,
    input  srtq_pkg::out_word_t  m_data,
    output int                   fail_count,
    output int                   pending_count
);

    localparam int DEPTH = srtq_pkg::TABLE_DEPTH_DEF;
    localparam int REPORT_CAP = srtq_pkg::MAX_REPORT_DEF;

    srtq_pkg::rec_t      table_copy[$];
    logic [15:0]         query_seq;
    srtq_pkg::out_word_t expected_words[$];

    function automatic bit ranks_ahead(srtq_pkg::rec_t a, srtq_pkg::rec_t b);
        if (a.worth != b.worth) begin
            return $signed(a.worth) > $signed(b.worth);
        end
        if (a.age != b.age) begin
            return a.age < b.age;
        end
        return a.name < b.name;
    endfunction

    task automatic insert_record(srtq_pkg::in_word_t w);
        srtq_pkg::rec_t r;
        int pos;
        if (table_copy.size() >= DEPTH) begin
            return;
        end
        r.name = w.person_name;
        r.age = w.person_age;
        r.worth = w.person_worth;
        pos = 0;
        while (pos < table_copy.size() && !ranks_ahead(r, table_copy[pos])) begin
            pos++;
        end
        table_copy.insert(pos, r);
    endtask

    task automatic predict_query(srtq_pkg::in_word_t w);
        int limit;
        int n;
        srtq_pkg::out_word_t o;
        query_seq = query_seq + 16'd1;
        limit = (w.report_limit > REPORT_CAP) ? REPORT_CAP : w.report_limit;
        n = 0;
        foreach (table_copy[j]) begin
            if (n < limit && table_copy[j].age >= w.age_low
                    && table_copy[j].age <= w.age_high) begin
                o.query_number = query_seq;
                o.found = 1'b1;
                o.out_name = table_copy[j].name;
                o.out_age = table_copy[j].age;
                o.out_worth = table_copy[j].worth;
                o.last = 1'b0;
                expected_words.push_back(o);
                n++;
            end
        end
        if (n == 0) begin
            o = '0;
            o.query_number = query_seq;
            o.last = 1'b1;
            expected_words.push_back(o);
        end else begin
            expected_words[expected_words.size() - 1].last = 1'b1;
        end
    endtask

    task automatic compare_word(srtq_pkg::out_word_t got);
        srtq_pkg::out_word_t exp;
        if (expected_words.size() == 0) begin
            $error("unexpected result word %h", got);
            fail_count++;
            return;
        end
        exp = expected_words.pop_front();
        if (got.query_number !== exp.query_number) begin
            $error("query_number expected %0d actual %0d", exp.query_number, got.query_number);
            fail_count++;
        end
        if (got.found !== exp.found) begin
            $error("found expected %0d actual %0d", exp.found, got.found);
            fail_count++;
        end
        if (got.out_name !== exp.out_name) begin
            $error("out_name expected %h actual %h", exp.out_name, got.out_name);
            fail_count++;
        end
        if (got.out_age !== exp.out_age) begin
            $error("out_age expected %0d actual %0d", exp.out_age, got.out_age);
            fail_count++;
        end
        if (got.out_worth !== exp.out_worth) begin
            $error("out_worth expected %h actual %h", exp.out_worth, got.out_worth);
            fail_count++;
        end
        if (got.last !== exp.last) begin
            $error("last expected %0d actual %0d", exp.last, got.last);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        query_seq = '0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                compare_word(m_data);
            end
            if (s_valid && s_ready) begin
                if (s_data.func == srtq_pkg::FUNC_LOAD) begin
                    insert_record(s_data);
                end else begin
                    predict_query(s_data);
                end
            end
        end
    end

    assign pending_count = expected_words.size();
endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
module testbench;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    srtq_pkg::in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    srtq_pkg::out_word_t m_data;
    int        fail_count;
    int        pending_count;
    bit        hold_off = 1'b0;
    logic [63:0] name_pool[8];
    logic [31:0] worth_pool[6];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    sorted_record_topk_range_query u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    topk_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Valid drops only when a gap follows, so back-to-back words keep it high.
    task automatic send_word(srtq_pkg::in_word_t w);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(logic [63:0] nm, logic [7:0] ag, logic [31:0] wo);
        srtq_pkg::in_word_t w;
        w = {rand64(), rand64()};
        w.func = srtq_pkg::FUNC_LOAD;
        w.person_name = nm;
        w.person_age = ag;
        w.person_worth = wo;
        send_word(w);
    endtask

    task automatic send_query(logic [6:0] lim, logic [7:0] lo, logic [7:0] hi);
        srtq_pkg::in_word_t w;
        w = {rand64(), rand64()};
        w.func = srtq_pkg::FUNC_QUERY;
        w.report_limit = lim;
        w.age_low = lo;
        w.age_high = hi;
        send_word(w);
    endtask

    // The receiver waits a random time before each word, and once for a long stretch.
    initial begin
        int gap;
        forever begin
            gap = $urandom_range(0, 19);
            if (hold_off) begin
                gap = 3000;
                hold_off = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int k;
        int wait_cycles;
        for (k = 0; k < 8; k++) begin
            name_pool[k] = rand64();
        end
        name_pool[0] = 64'h416C_6963_6500_0000;
        name_pool[1] = 64'h416C_6963_6500_0001;
        worth_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd1000, 32'd1000};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extremes, equal keys, ties on worth and age.
        send_query(7'd64, 8'd0, 8'd255);
        send_load(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 32'h7FFF_FFFF);
        send_load(64'h0, 8'd0, 32'h8000_0000);
        send_load(name_pool[0], 8'd30, 32'd1000);
        send_load(name_pool[1], 8'd30, 32'd1000);
        send_load(name_pool[0], 8'd30, 32'd1000);
        send_load(name_pool[0], 8'd20, 32'd1000);
        send_load(64'h5555_AAAA_5555_AAAA, 8'hAA, 32'h5555_AAAA);
        send_load(64'hAAAA_5555_AAAA_5555, 8'h55, 32'hAAAA_5555);
        send_query(7'd64, 8'd0, 8'd255);
        send_query(7'd127, 8'd0, 8'd255);
        send_query(7'd0, 8'd0, 8'd255);
        send_query(7'd2, 8'd20, 8'd40);
        send_query(7'd10, 8'd50, 8'd40);
        send_query(7'd1, 8'd255, 8'd255);
        send_query(7'd64, 8'd100, 8'd120);

        // Random part: a pooled key set keeps ties common.
        for (k = 0; k < 150; k++) begin
            if (k == 60) begin
                hold_off = 1'b1;
            end
            if ($urandom_range(0, 2) != 0) begin
                send_load($urandom_range(0, 3) == 0 ? rand64() : name_pool[$urandom_range(0, 7)],
                          $urandom_range(0, 1) ? 8'($urandom_range(20, 40))
                                               : 8'($urandom()),
                          $urandom_range(0, 1) ? worth_pool[$urandom_range(0, 5)]
                                               : $urandom());
            end else begin
                send_query(7'($urandom_range(0, 127)), 8'($urandom_range(0, 60)),
                           $urandom_range(0, 3) == 0 ? 8'($urandom())
                                                     : 8'($urandom_range(20, 255)));
            end
            // Bursts of queries hit the hold-off phase while it is active.
            if (k >= 60 && k < 70) begin
                send_query(7'd64, 8'd0, 8'd255);
            end
        end
        s_valid <= 1'b0;

        // Drain the outstanding result words before the verdict.
        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 400000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (3000) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
